// File: sv/odr_pkg.sv
// ----------------------------------------------------------------------------
// odr_pkg: shared types and helpers for the OBD text response decoder
// Result layout, line phases, status codes and character classification.
// ----------------------------------------------------------------------------
package odr_pkg;

    localparam int MAX_BYTES_DEF = 64;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PROMPT = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;

    localparam int NODATA_LEN = 7;
    localparam int ERROR_LEN  = 5;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        PH_ID   = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_REPLY_ERR = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        logic [6:0] total_length;
        logic [1:0] status;
        logic       last;
    } t_result;

    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    // Returns {valid, value} for one hex digit, either case.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    endfunction

    function automatic logic [7:0] group_value(input logic [7:0] a, input logic [7:0] b,
                                               input logic have_b);
        logic [4:0] ha;
        logic [4:0] hb;
        logic [7:0] v;
        ha = hex_digit(a);
        hb = have_b ? hex_digit(b) : 5'd0;
        if (is_blank(a)) begin
            v = hb[4] ? {4'd0, hb[3:0]} : 8'd0;
        end else if (!ha[4]) begin
            v = 8'd0;
        end else if (hb[4]) begin
            v = {ha[3:0], hb[3:0]};
        end else begin
            v = {4'd0, ha[3:0]};
        end
        return v;
    endfunction

    function automatic logic [7:0] nodata_ch(input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0: c = 8'h4E;
            3'd1: c = 8'h4F;
            3'd2: c = 8'h20;
            3'd3: c = 8'h44;
            3'd4: c = 8'h41;
            3'd5: c = 8'h54;
            3'd6: c = 8'h41;
            default: c = 8'h4E;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] error_ch(input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0: c = 8'h45;
            3'd1: c = 8'h52;
            3'd2: c = 8'h52;
            3'd3: c = 8'h4F;
            3'd4: c = 8'h52;
            default: c = 8'h45;
        endcase
        return c;
    endfunction

    // Returns {hit, next progress} of the "NO DATA" matcher.
    function automatic logic [3:0] adv_nodata(input logic [2:0] prog, input logic [7:0] c);
        logic [2:0] p;
        logic       hit;
        p   = (prog >= 3'(NODATA_LEN)) ? 3'd0 : prog;
        hit = 1'b0;
        if (c == nodata_ch(p)) begin
            p = p + 3'd1;
        end else begin
            p = (c == nodata_ch(3'd0)) ? 3'd1 : 3'd0;
        end
        if (p == 3'(NODATA_LEN)) begin
            hit = 1'b1;
            p   = 3'd0;
        end
        return {hit, p};
    endfunction

    // Returns {hit, next progress} of the "ERROR" matcher.
    function automatic logic [3:0] adv_error(input logic [2:0] prog, input logic [7:0] c);
        logic [2:0] p;
        logic       hit;
        p   = (prog >= 3'(ERROR_LEN)) ? 3'd0 : prog;
        hit = 1'b0;
        if (c == error_ch(p)) begin
            p = p + 3'd1;
        end else begin
            p = (c == error_ch(3'd0)) ? 3'd1 : 3'd0;
        end
        if (p == 3'(ERROR_LEN)) begin
            hit = 1'b1;
            p   = 3'd0;
        end
        return {hit, p};
    endfunction

endpackage

// File: sv/odr_core.sv
// ----------------------------------------------------------------------------
// odr_core: character register and line parser
// Holds the registered input character and the parser state, and produces
// up to two results for each character it consumes.
// ----------------------------------------------------------------------------
module odr_core #(
    parameter int MAX_BYTES = odr_pkg::MAX_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [7:0]    i_in_char,
    output logic          o_in_ready,
    input  logic          i_room,
    output odr_pkg::t_push o_push
);
    import odr_pkg::*;

    localparam int CW = $clog2(MAX_BYTES + 1);

    logic          r_valid;
    logic [7:0]    r_char;
    t_phase        r_phase,   n_phase;
    logic [1:0]    r_gp,      n_gp;
    logic [7:0]    r_first,   n_first;
    logic          r_pending, n_pending;
    logic [CW-1:0] r_count,   n_count;
    logic [2:0]    r_nd,      n_nd;
    logic [2:0]    r_er,      n_er;
    logic          r_err,     n_err;
    logic          r_ovf,     n_ovf;

    logic          consume;
    logic [3:0]    nd_adv;
    logic [3:0]    er_adv;
    logic          room_byte;
    logic          byte_ok;
    logic          ovf_now;
    logic [CW-1:0] cnt1;
    t_result       byte_res;
    t_result       sum_res;
    logic [7:0]    byte_val;

    assign consume    = r_valid && i_room;
    assign o_in_ready = !r_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_phase   <= PH_ID;
            r_gp      <= 2'd0;
            r_first   <= 8'd0;
            r_pending <= 1'b0;
            r_count   <= '0;
            r_nd      <= 3'd0;
            r_er      <= 3'd0;
            r_err     <= 1'b0;
            r_ovf     <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_valid <= i_in_valid;
            end
            r_phase   <= n_phase;
            r_gp      <= n_gp;
            r_first   <= n_first;
            r_pending <= n_pending;
            r_count   <= n_count;
            r_nd      <= n_nd;
            r_er      <= n_er;
            r_err     <= n_err;
            r_ovf     <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_char <= i_in_char;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_gp      = r_gp;
        n_first   = r_first;
        n_pending = r_pending;
        n_count   = r_count;
        n_nd      = r_nd;
        n_er      = r_er;
        n_err     = r_err;
        n_ovf     = r_ovf;
        o_push    = '0;

        nd_adv    = adv_nodata(r_nd, r_char);
        er_adv    = adv_error(r_er, r_char);
        room_byte = r_count < CW'(MAX_BYTES);

        // A byte is either the flushed lone character or a completed pair.
        if (r_gp == 2'd1 && r_phase != PH_ID && r_phase != PH_LEN) begin
            byte_val = group_value(r_first, r_char, 1'b1);
        end else begin
            byte_val = group_value(r_first, 8'd0, 1'b0);
        end

        byte_res              = '0;
        byte_res.kind         = KIND_BYTE;
        byte_res.data_byte    = byte_val;
        byte_res.byte_index   = 6'(r_count);

        byte_ok = r_pending && room_byte;
        ovf_now = r_ovf || (r_pending && !room_byte);
        cnt1    = byte_ok ? r_count + CW'(1) : r_count;

        sum_res              = '0;
        sum_res.kind         = KIND_SUMMARY;
        sum_res.total_length = 7'(cnt1);
        sum_res.last         = 1'b1;
        if (r_err || nd_adv[3] || er_adv[3]) begin
            sum_res.status = ST_REPLY_ERR;
        end else if (ovf_now) begin
            sum_res.status = ST_OVERFLOW;
        end else begin
            sum_res.status = ST_GOOD;
        end

        if (consume) begin
            n_nd  = nd_adv[2:0];
            n_er  = er_adv[2:0];
            n_err = r_err || nd_adv[3] || er_adv[3];

            if (r_char == CH_PROMPT) begin
                if (byte_ok) begin
                    o_push.v0 = 1'b1;
                    o_push.r0 = byte_res;
                    o_push.v1 = 1'b1;
                    o_push.r1 = sum_res;
                end else begin
                    o_push.v0 = 1'b1;
                    o_push.r0 = sum_res;
                end
                n_phase   = PH_ID;
                n_gp      = 2'd0;
                n_first   = 8'd0;
                n_pending = 1'b0;
                n_count   = '0;
                n_nd      = 3'd0;
                n_er      = 3'd0;
                n_err     = 1'b0;
                n_ovf     = 1'b0;
            end else if (r_char == CH_CR || r_char == CH_LF) begin
                if (byte_ok) begin
                    o_push.v0      = 1'b1;
                    o_push.r0      = byte_res;
                    o_push.r0.last = 1'b1;
                end
                n_count   = cnt1;
                n_ovf     = ovf_now;
                n_pending = 1'b0;
                n_phase   = PH_ID;
                n_gp      = 2'd0;
            end else begin
                unique case (r_phase)
                    PH_ID: begin
                        if (r_char == CH_SPACE) begin
                            n_phase = PH_LEN;
                            n_gp    = 2'd0;
                        end
                    end
                    PH_LEN: begin
                        if (r_gp == 2'd2) begin
                            n_phase = PH_DATA;
                            n_gp    = 2'd0;
                        end else begin
                            n_gp = r_gp + 2'd1;
                        end
                    end
                    default: begin
                        if (r_gp == 2'd0) begin
                            n_first   = r_char;
                            n_pending = 1'b1;
                            n_gp      = 2'd1;
                        end else if (r_gp == 2'd1) begin
                            if (room_byte) begin
                                o_push.v0      = 1'b1;
                                o_push.r0      = byte_res;
                                o_push.r0.last = 1'b1;
                                n_count        = r_count + CW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                            n_pending = 1'b0;
                            n_gp      = 2'd2;
                        end else begin
                            n_gp = 2'd0;
                        end
                    end
                endcase
            end
        end
    end

endmodule

// File: sv/odr_fifo.sv
// ----------------------------------------------------------------------------
// odr_fifo: result queue
// Small register queue that takes up to two results per cycle and hands
// one per cycle to the output channel while it is ready.
// ----------------------------------------------------------------------------
module odr_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  odr_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output odr_pkg::t_result o_res
);
    import odr_pkg::*;

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     r_wp, n_wp;
    logic [FIFO_AW-1:0]     r_rp, n_rp;
    logic [FIFO_AW:0]       r_cnt, n_cnt;
    logic                   pop;
    logic [FIFO_AW:0]       n_in;
    logic [FIFO_AW-1:0]     wp1;

    assign o_valid = r_cnt != '0;
    assign o_res   = r_mem[r_rp];
    assign o_room  = r_cnt <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);
    assign pop     = o_valid && i_ready;
    assign wp1     = r_wp + FIFO_AW'(1);

    always_comb begin
        n_in  = (FIFO_AW + 1)'(i_push.v0) + (FIFO_AW + 1)'(i_push.v1);
        n_wp  = r_wp + n_in[FIFO_AW-1:0];
        n_rp  = pop ? r_rp + FIFO_AW'(1) : r_rp;
        n_cnt = r_cnt + n_in - (FIFO_AW + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[wp1] <= i_push.r1;
        end
    end

endmodule

// File: sv/obd_text_response_decoder.sv
// Throughput: one character per cycle while the result queue has room;
// one result leaves per cycle while the output is ready.
// A prompt with a pending byte that fits gives two results.
// Reset is synchronous and active low and returns the parser to line start.
// ----------------------------------------------------------------------------
// obd_text_response_decoder: OBD adapter text reply decoder
// Parses reply text into data bytes and an end of response summary.
// ----------------------------------------------------------------------------
module obd_text_response_decoder #(
    parameter int MAX_BYTES = odr_pkg::MAX_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_char,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_kind,
    output logic [7:0] o_data_byte,
    output logic [5:0] o_byte_index,
    output logic [6:0] o_total_length,
    output logic [1:0] o_status,
    output logic       o_last
);
    import odr_pkg::*;

    t_push   push;
    logic    room;
    t_result res;

    odr_core #(
        .MAX_BYTES(MAX_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_char  (i_in_char),
        .o_in_ready (o_in_ready),
        .i_room     (room),
        .o_push     (push)
    );

    odr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (res)
    );

    assign o_kind         = res.kind;
    assign o_data_byte    = res.data_byte;
    assign o_byte_index   = res.byte_index;
    assign o_total_length = res.total_length;
    assign o_status       = res.status;
    assign o_last         = res.last;

endmodule
